>>> rtl/frt_pkg.sv
// Shared types, constants and helpers for the fragment reassembly tracker.
// Used by every module under rtl/; depends on nothing.
package frt_pkg;

  localparam int SLOTS = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(SLOTS - 1);

  localparam logic [31:0] TYPE_COMMAND_DONE    = 32'h8000_0003;
  localparam logic [31:0] TYPE_INDICATE_STATUS = 32'h8000_0007;

  typedef enum logic [2:0] {
    VERDICT_PENDING        = 3'd0,
    VERDICT_COMPLETE       = 3'd1,
    VERDICT_WRONG_TYPE     = 3'd2,
    VERDICT_NO_START       = 3'd3,
    VERDICT_COUNT_MISMATCH = 3'd4,
    VERDICT_OUT_OF_ORDER   = 3'd5,
    VERDICT_TABLE_FULL     = 3'd6
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TYPE_A,
    ST_TYPE_B,
    ST_SCAN,
    ST_CHK_TOTAL,
    ST_CHK_ORDER,
    ST_CHK_MORE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    UOP_EQ,      // a == b
    UOP_INC_EQ,  // a + 1 == b (32-bit wrap)
    UOP_INC_LT   // a + 1 < b (33-bit)
  } unit_op_t;

  typedef enum logic [1:0] {
    TWR_NONE,
    TWR_ALLOC,
    TWR_SET_LAST,
    TWR_FREE
  } tbl_op_t;

  typedef struct packed {
    logic [31:0] tid;
    logic [31:0] total;
    logic [31:0] last;
  } entry_t;

  typedef struct packed {
    tbl_op_t           op;
    logic [SLOT_W-1:0] addr;
    entry_t            entry;
  } tbl_wr_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [2:0]  slot;
    logic [31:0] tid;
  } result_t;

  // slot number as reported: low three bits, zero extended when narrower
  function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+2:0] w;
    w = (SLOT_W + 3)'(s);
    return w[2:0];
  endfunction

endpackage

>>> rtl/frt_unit.sv
// Shared 32-bit compare / increment unit used by the sequencer for every check.
// Depends on frt_pkg.
module frt_unit (
  input  frt_pkg::unit_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              flag
);
  import frt_pkg::*;

  logic [32:0] sum;

  assign sum = {1'b0, a} + 33'd1;

  always_comb begin
    case (op)
      UOP_EQ:     flag = (a == b);
      UOP_INC_EQ: flag = (sum[31:0] == b);
      UOP_INC_LT: flag = (sum < {1'b0, b});
      default:    flag = 1'b0;
    endcase
  end

endmodule

>>> rtl/frt_table.sv
// Open-transaction table: per-slot valid flops plus id / total / last index.
// One read address, one write per cycle. Depends on frt_pkg.
module frt_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [frt_pkg::SLOT_W-1:0] rd_addr,
  output logic                       rd_valid,
  output frt_pkg::entry_t            rd_entry,
  input  frt_pkg::tbl_wr_t           wr
);
  import frt_pkg::*;

  logic [SLOTS-1:0] valid;
  entry_t           entries [SLOTS];

  assign rd_valid = valid[rd_addr];
  assign rd_entry = entries[rd_addr];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      case (wr.op)
        TWR_ALLOC: valid[wr.addr] <= 1'b1;
        TWR_FREE:  valid[wr.addr] <= 1'b0;
        default:   ;
      endcase
    end
  end

  // payload carries no reset; only read behind a valid bit
  always_ff @(posedge clk) begin
    case (wr.op)
      TWR_ALLOC:    entries[wr.addr] <= wr.entry;
      TWR_SET_LAST: entries[wr.addr].last <= wr.entry.last;
      default:      ;
    endcase
  end

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    wr.op == TWR_ALLOC |-> !valid[wr.addr])
    else $error("allocation into an occupied slot");

  a_free_open_slot: assert property (@(posedge clk) disable iff (rst)
    wr.op == TWR_FREE |-> valid[wr.addr])
    else $error("freeing a slot that is not open");

  a_update_open_slot: assert property (@(posedge clk) disable iff (rst)
    wr.op == TWR_SET_LAST |-> valid[wr.addr])
    else $error("index update on a slot that is not open");

endmodule

>>> rtl/frt_seq.sv
// Sequencer: type check, slot scan and entry checks, all through frt_unit.
// Depends on frt_pkg, frt_unit, frt_table.
module frt_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [31:0]      in_tid,
  input  logic [31:0]      in_type,
  input  logic [31:0]      in_total,
  input  logic [31:0]      in_index,
  output logic             res_valid,
  input  logic             res_take,
  output frt_pkg::result_t res
);
  import frt_pkg::*;

  state_t            state, state_next;
  logic [SLOT_W-1:0] cnt, cnt_next;
  logic [SLOT_W-1:0] hit, hit_next;
  logic [SLOT_W-1:0] free_slot, free_slot_next;
  logic              free_found, free_found_next;
  logic [31:0]       tid, tid_next;
  logic [31:0]       mtype, mtype_next;
  logic [31:0]       total, total_next;
  logic [31:0]       index, index_next;
  verdict_t          verdict, verdict_next;
  logic [2:0]        slot, slot_next;

  unit_op_t          u_op;
  logic [31:0]       u_a, u_b;
  logic              u_flag;

  logic [SLOT_W-1:0] rd_addr;
  logic              rd_valid;
  entry_t            rd_entry;
  tbl_wr_t           wr;

  logic [SLOT_W-1:0] new_slot;
  logic              free_any;

  frt_unit u_unit (
    .op   (u_op),
    .a    (u_a),
    .b    (u_b),
    .flag (u_flag)
  );

  frt_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  assign new_slot = free_found ? free_slot : cnt;
  assign free_any = free_found | ~rd_valid;

  assign res.verdict = verdict;
  assign res.slot    = slot;
  assign res.tid     = tid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_found <= 1'b0;
    end else begin
      state      <= state_next;
      free_found <= free_found_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    hit       <= hit_next;
    free_slot <= free_slot_next;
    tid       <= tid_next;
    mtype     <= mtype_next;
    total     <= total_next;
    index     <= index_next;
    verdict   <= verdict_next;
    slot      <= slot_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    hit_next        = hit;
    free_slot_next  = free_slot;
    free_found_next = free_found;
    tid_next        = tid;
    mtype_next      = mtype;
    total_next      = total;
    index_next      = index;
    verdict_next    = verdict;
    slot_next       = slot;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    u_op            = UOP_EQ;
    u_a             = mtype;
    u_b             = TYPE_COMMAND_DONE;
    rd_addr         = cnt;
    wr.op           = TWR_NONE;
    wr.addr         = hit;
    wr.entry.tid    = tid;
    wr.entry.total  = total;
    wr.entry.last   = index;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          tid_next        = in_tid;
          mtype_next      = in_type;
          total_next      = in_total;
          index_next      = in_index;
          cnt_next        = '0;
          free_found_next = 1'b0;
          state_next      = ST_TYPE_A;
        end
      end

      ST_TYPE_A: begin
        state_next = u_flag ? ST_SCAN : ST_TYPE_B;
      end

      ST_TYPE_B: begin
        u_b = TYPE_INDICATE_STATUS;
        if (u_flag) begin
          state_next = ST_SCAN;
        end else begin
          verdict_next = VERDICT_WRONG_TYPE;
          slot_next    = 3'd0;
          state_next   = ST_EMIT;
        end
      end

      // one slot per cycle; lowest free slot is remembered on the way
      ST_SCAN: begin
        u_a = rd_entry.tid;
        u_b = tid;
        if (rd_valid && u_flag) begin
          hit_next   = cnt;
          state_next = ST_CHK_TOTAL;
        end else begin
          if (!rd_valid && !free_found) begin
            free_slot_next  = cnt;
            free_found_next = 1'b1;
          end
          if (cnt == SCAN_LAST) begin
            state_next = ST_EMIT;
            slot_next  = 3'd0;
            if (index != 32'd0) begin
              verdict_next = VERDICT_NO_START;
            end else if (total == 32'd1) begin
              verdict_next = VERDICT_COMPLETE;
            end else if (total == 32'd0) begin
              verdict_next = VERDICT_COUNT_MISMATCH;
            end else if (free_any) begin
              wr.op         = TWR_ALLOC;
              wr.addr       = new_slot;
              wr.entry.last = 32'd0;
              verdict_next  = VERDICT_PENDING;
              slot_next     = slot_field(new_slot);
            end else begin
              verdict_next = VERDICT_TABLE_FULL;
            end
          end else begin
            cnt_next = cnt + SLOT_W'(1);
          end
        end
      end

      ST_CHK_TOTAL: begin
        rd_addr = hit;
        u_a     = rd_entry.total;
        u_b     = total;
        if (u_flag) begin
          state_next = ST_CHK_ORDER;
        end else begin
          verdict_next = VERDICT_COUNT_MISMATCH;
          slot_next    = slot_field(hit);
          state_next   = ST_EMIT;
        end
      end

      ST_CHK_ORDER: begin
        rd_addr = hit;
        u_op    = UOP_INC_EQ;
        u_a     = rd_entry.last;
        u_b     = index;
        if (u_flag) begin
          wr.op      = TWR_SET_LAST;
          state_next = ST_CHK_MORE;
        end else begin
          verdict_next = VERDICT_OUT_OF_ORDER;
          slot_next    = slot_field(hit);
          state_next   = ST_EMIT;
        end
      end

      ST_CHK_MORE: begin
        rd_addr   = hit;
        u_op      = UOP_INC_LT;
        u_a       = index;
        u_b       = total;
        slot_next = slot_field(hit);
        if (u_flag) begin
          verdict_next = VERDICT_PENDING;
        end else begin
          wr.op        = TWR_FREE;
          verdict_next = VERDICT_COMPLETE;
        end
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fragment_reassembly_tracker_core.sv
// Top level of the fragment reassembly tracker: stream ports, output register.
// Depends on frt_pkg and frt_seq (which holds frt_unit and frt_table).
//
//  channel | dir | payload (tdata, low bit up)                        | handshake
//  s_axis  | in  | transaction_id, message_type, fragment_total, index | s_tvalid/s_tready
//  m_axis  | out | verdict, slot, done_transaction, 2 pad bits         | m_tvalid/m_tready
//
// From acceptance to result a fragment passes a type check against the two
// tracked types, a table scan at one slot per cycle, up to 3 entry checks,
// then the hand-off to the output register; all checks share one compare unit.
// rst is synchronous; it closes all table entries and empties the output.
// A result waiting on m_tready does not block the next fragment's work
// until that fragment reaches its own hand-off.
module fragment_reassembly_tracker_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // transaction_id, message_type, fragment_total, fragment_index
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata    // verdict[2:0], slot[5:3], done_transaction[37:6], zeros
);
  import frt_pkg::*;

  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_q;

  frt_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_tid    (s_tdata[31:0]),
    .in_type   (s_tdata[63:32]),
    .in_total  (s_tdata[95:64]),
    .in_index  (s_tdata[127:96]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_tdata = {2'b00, out_q.tid, out_q.slot, out_q.verdict};

endmodule

>>> dv/tb_fragment_reassembly_tracker_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for fragment_reassembly_tracker_core: directed and random
// fragment headers, with random gaps and stalls. Depends on frt_pkg and the RTL.
module tb_fragment_reassembly_tracker_core;
  import frt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 380;
  localparam int TAIL_ITEMS   = 60;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [31:0] tid;
    logic [31:0] msg_type;
    logic [31:0] total;
    logic [31:0] index;
  } frag_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // transaction_id, message_type, fragment_total, fragment_index
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;        // verdict, slot, done_transaction, zero pad
  logic         tail_phase = 1'b0;

  fragment_reassembly_tracker_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  frag_t   fragment_q[$];
  result_t verdict_q[$];
  int      fail_count = 0;

  // shadow of the open-transaction table
  logic        open_valid[SLOTS];
  logic [31:0] open_tid[SLOTS];
  logic [31:0] open_total[SLOTS];
  logic [31:0] open_last[SLOTS];

  initial begin
    for (int i = 0; i < SLOTS; i++) open_valid[i] = 1'b0;
  end

  function automatic result_t judge_fragment(frag_t f);
    result_t r;
    int      hit;
    int      free_slot;
    int      i;
    r.tid = f.tid;
    r.slot = 3'd0;
    hit = -1;
    free_slot = -1;
    if (f.msg_type != TYPE_COMMAND_DONE && f.msg_type != TYPE_INDICATE_STATUS) begin
      r.verdict = VERDICT_WRONG_TYPE;
      return r;
    end
    // walk downward so the lowest match and the lowest free slot win
    for (i = SLOTS - 1; i >= 0; i--) begin
      if (open_valid[i] && open_tid[i] == f.tid) hit = i;
      if (!open_valid[i]) free_slot = i;
    end
    if (hit < 0) begin
      if (f.index != 32'd0) r.verdict = VERDICT_NO_START;
      else if (f.total == 32'd1) r.verdict = VERDICT_COMPLETE;
      else if (f.total == 32'd0) r.verdict = VERDICT_COUNT_MISMATCH;
      else if (free_slot < 0) r.verdict = VERDICT_TABLE_FULL;
      else begin
        open_valid[free_slot] = 1'b1;
        open_tid[free_slot]   = f.tid;
        open_total[free_slot] = f.total;
        open_last[free_slot]  = 32'd0;
        r.verdict = VERDICT_PENDING;
        r.slot    = 3'(free_slot);
      end
      return r;
    end
    r.slot = 3'(hit);
    if (open_total[hit] != f.total) r.verdict = VERDICT_COUNT_MISMATCH;
    else if (open_last[hit] + 32'd1 != f.index) r.verdict = VERDICT_OUT_OF_ORDER;
    else begin
      open_last[hit] = f.index;
      if ({1'b0, f.index} + 33'd1 < {1'b0, f.total}) r.verdict = VERDICT_PENDING;
      else begin
        open_valid[hit] = 1'b0;
        r.verdict = VERDICT_COMPLETE;
      end
    end
    return r;
  endfunction

  task automatic queue_fragment(input logic [31:0] tid, input logic [31:0] msg_type,
                                input logic [31:0] total, input logic [31:0] index);
    frag_t f;
    f.tid = tid;
    f.msg_type = msg_type;
    f.total = total;
    f.index = index;
    fragment_q.push_back(f);
  endtask

  function automatic logic [31:0] any_tracked_type();
    return ($urandom_range(0, 1) == 0) ? TYPE_COMMAND_DONE : TYPE_INDICATE_STATUS;
  endfunction

  // input side: one transaction per handshake, gap bursts between runs
  int send_gap = 0;
  int send_run = 0;

  always @(posedge clk) begin : drive
    frag_t f;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tail_phase <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        f.tid      = s_tdata[31:0];
        f.msg_type = s_tdata[63:32];
        f.total    = s_tdata[95:64];
        f.index    = s_tdata[127:96];
        verdict_q.push_back(judge_fragment(f));
      end
      tail_phase <= (fragment_q.size() < TAIL_ITEMS);
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (fragment_q.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (send_run == 0 && !tail_phase) begin
          send_gap = $urandom_range(1, 15) - 1;
          send_run = $urandom_range(0, 40);
          s_tvalid <= 1'b0;
        end else begin
          if (send_run > 0) send_run--;
          f = fragment_q.pop_front();
          s_tdata  <= {f.index, f.total, f.msg_type, f.tid};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // output side: check each result, stall in bursts
  int take_gap = 0;
  int take_run = 0;

  always @(posedge clk) begin : observe
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %h", m_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[2:0] != want.verdict || m_tdata[5:3] != want.slot ||
              m_tdata[37:6] != want.tid || m_tdata[39:38] != 2'b00) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp verdict %0d slot %0d tid %h | got verdict %0d slot %0d tid %h pad %b",
                       want.verdict, want.slot, want.tid,
                       m_tdata[2:0], m_tdata[5:3], m_tdata[37:6], m_tdata[39:38]);
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else if (take_run == 0 && !tail_phase) begin
        take_gap = $urandom_range(1, 15) - 1;
        take_run = $urandom_range(0, 40);
        m_tready <= 1'b0;
      end else begin
        if (take_run > 0) take_run--;
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] msg_tid[$];
    logic [31:0] msg_total[$];
    logic [31:0] msg_next[$];
    logic [31:0] t;
    logic [31:0] v;
    int          made;
    int          pick;
    int          i;
    int          stuck;
    int          pool_cap;

    // directed: type filter and the no-entry cases
    queue_fragment(32'h0, 32'h0, 32'h0, 32'h0);
    queue_fragment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_fragment(32'h11, 32'h8000_0005, 32'd2, 32'd0);
    queue_fragment(32'h0, TYPE_COMMAND_DONE, 32'd1, 32'd0);
    queue_fragment(32'hFFFF_FFFF, TYPE_INDICATE_STATUS, 32'd0, 32'd0);
    queue_fragment(32'h5, TYPE_COMMAND_DONE, 32'd3, 32'hFFFF_FFFF);
    // one three-fragment message with a bad count and a skipped index in between
    queue_fragment(32'hA5A5_0001, TYPE_COMMAND_DONE, 32'd3, 32'd0);
    queue_fragment(32'hA5A5_0001, TYPE_COMMAND_DONE, 32'hFFFF_FFFF, 32'd1);
    queue_fragment(32'hA5A5_0001, TYPE_INDICATE_STATUS, 32'd3, 32'd2);
    queue_fragment(32'hA5A5_0001, TYPE_INDICATE_STATUS, 32'd3, 32'd1);
    queue_fragment(32'hA5A5_0001, TYPE_COMMAND_DONE, 32'd3, 32'd2);
    // fill every slot, overflow, then free slot 0 and reuse it
    for (i = 0; i < SLOTS; i++)
      queue_fragment(32'hB000_0000 + i, any_tracked_type(), 32'd2, 32'd0);
    queue_fragment(32'hC0C0_C0C0, TYPE_COMMAND_DONE, 32'd2, 32'd0);
    queue_fragment(32'hB000_0000, TYPE_COMMAND_DONE, 32'd2, 32'd1);
    queue_fragment(32'hC0C0_C0C0, TYPE_INDICATE_STATUS, 32'd2, 32'd0);
    for (i = 1; i < SLOTS; i++) begin
      msg_tid.push_back(32'hB000_0000 + i);
      msg_total.push_back(32'd2);
      msg_next.push_back(32'd1);
    end
    msg_tid.push_back(32'hC0C0_C0C0);
    msg_total.push_back(32'd2);
    msg_next.push_back(32'd1);

    // random: mostly in-order messages, interleaved, with noise and broken fragments
    made = 0;
    stuck = 0;
    pool_cap = 8;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        t = $urandom;
        if (t == TYPE_COMMAND_DONE || t == TYPE_INDICATE_STATUS) t = t ^ 32'h10;
        queue_fragment($urandom, t, $urandom, $urandom);
        continue;
      end
      made++;
      if (pick < 12) begin
        v = $urandom;
        if (v == 32'd0) v = 32'd1;
        queue_fragment($urandom, any_tracked_type(), $urandom, v);
      end else if (pick < 20 && msg_tid.size() > 0) begin
        i = $urandom_range(0, msg_tid.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            v = $urandom;
            if (v == msg_total[i]) v = v + 32'd1;
            queue_fragment(msg_tid[i], any_tracked_type(), v, msg_next[i]);
          end
          1: begin
            v = $urandom;
            if (v == msg_next[i]) v = v + 32'd1;
            queue_fragment(msg_tid[i], any_tracked_type(), msg_total[i], v);
          end
          default: queue_fragment(msg_tid[i], any_tracked_type(), msg_total[i], 32'd0);
        endcase
      end else if (pick < 24) begin
        queue_fragment($urandom, any_tracked_type(),
                       ($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1, 32'd0);
      end else if (pick < 25 && stuck < 2) begin
        // a start that can never finish keeps its slot for the rest of the run
        queue_fragment($urandom, any_tracked_type(), $urandom | 32'h8000_0000, 32'd0);
        stuck++;
      end else if (msg_tid.size() == 0 ||
                   (msg_tid.size() < pool_cap && $urandom_range(0, 2) == 0)) begin
        t = $urandom;
        v = $urandom_range(2, 6);
        queue_fragment(t, any_tracked_type(), v, 32'd0);
        msg_tid.push_back(t);
        msg_total.push_back(v);
        msg_next.push_back(32'd1);
        pool_cap = $urandom_range(5, 9);
      end else begin
        i = $urandom_range(0, msg_tid.size() - 1);
        queue_fragment(msg_tid[i], any_tracked_type(), msg_total[i], msg_next[i]);
        msg_next[i] = msg_next[i] + 32'd1;
        if (msg_next[i] == msg_total[i]) begin
          msg_tid.delete(i);
          msg_total.delete(i);
          msg_next.delete(i);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (fragment_q.size() != 0 || s_tvalid) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
